### design/assert_macros.svh
// Assertion macros for the evaluator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/pse_pkg.sv
// Shared types and codes for the postfix stack evaluator.
// No dependencies.
`default_nettype none
package pse_pkg;
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_DEPTH     = 3'd4;

    typedef struct packed {
        logic        start;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic signed [31:0] q;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage
`default_nettype wire

### design/pse_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/pse_div.sv
// Iterative signed divider: (a << FRACTION_BITS) / b, truncated, saturated.
// Depends on pse_pkg. One quotient bit per cycle.
`default_nettype none
module pse_div #(
    parameter int FRACTION_BITS = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    input  pse_pkg::div_req_t req,
    output pse_pkg::div_rsp_t rsp
);
    localparam int NB = 32 + FRACTION_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]   num_reg;
    logic [31:0]     rem_reg;
    logic [31:0]     den_reg;
    logic            neg_reg;
    logic            busy_reg;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;
    logic signed [31:0] q_reg;

    logic [31:0]     abs_a;
    logic [31:0]     abs_b;
    logic [32:0]     trial;
    logic [32:0]     diff;
    logic [NB:0]     mag;
    logic signed [NB+1:0] sq;

    assign abs_a = req.a[31] ? 32'(-req.a) : 32'(req.a);
    assign abs_b = req.b[31] ? 32'(-req.b) : 32'(req.b);
    assign trial = {rem_reg, num_reg[NB-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign mag   = {1'b0, num_reg[NB-2:0], ~diff[32]};
    assign sq    = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            neg_reg  <= 1'b0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
                rem_reg  <= '0;
                num_reg  <= NB'(abs_a) << FRACTION_BITS;
                den_reg  <= abs_b;
                neg_reg  <= req.a[31] ^ req.b[31];
            end
            else if (busy_reg)
            begin
                rem_reg <= diff[32] ? trial[31:0] : diff[31:0];
                num_reg <= {num_reg[NB-2:0], ~diff[32]};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    q_reg    <= pse_pkg::sat32(66'(sq));
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;
endmodule
`default_nettype wire

### design/postfix_stack_evaluator_core.sv
// Top level of the postfix stack evaluator.
// Depends on pse_pkg, pse_ram, pse_div, assert_macros.svh.
//
// channel | dir | signals
// in      | in  | in_valid in_ready func push_value last
// out     | out | out_valid out_ready result_value status
//
// Push, unused code or error: completes when accepted; add/sub: read top,
// read second, write back; multiply: adds a registered product step;
// divide: waits on the bit-serial divider. A last instruction stalls
// while a result waits on out_ready. Reset empties the stack; no clearing
// pass.
`default_nettype none
`include "assert_macros.svh"
module postfix_stack_evaluator_core #(
    parameter int STACK_ENTRIES = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [2:0]         func,
    input  wire  signed [31:0] push_value,
    input  wire                last,
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [31:0] result_value,
    output logic [2:0]         status
);
    localparam int AW = $clog2(STACK_ENTRIES);
    localparam int DW = $clog2(STACK_ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [2:0]         err_reg, err_next;
    logic [2:0]         op_reg, op_next;
    logic               last_reg, last_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] res_reg, res_next;
    logic [2:0]         st_reg, st_next;
    logic signed [31:0] bottom_reg, bottom_next;
    logic               out_valid_reg, out_valid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    pse_pkg::div_req_t dreq;
    pse_pkg::div_rsp_t drsp;

    logic acc, fin, wr_done;
    logic signed [65:0] sum;
    logic signed [63:0] mul_hi;
    logic signed [31:0] res_val;

    pse_ram #(.WIDTH(32), .DEPTH(STACK_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    pse_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp)
    );

    assign in_ready = (state_reg == S_IDLE) && !(last && out_valid_reg);
    assign acc      = in_valid && in_ready;
    assign sum      = (op_reg == pse_pkg::OP_SUB) ? 66'(a_reg) - 66'(b_reg)
                                                  : 66'(a_reg) + 66'(b_reg);
    assign mul_hi   = prod_reg >>> (31 + FRACTION_BITS);

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        bottom_next    = bottom_reg;
        out_valid_next = out_valid_reg && !out_ready;
        we         = 1'b0;
        waddr      = AW'(depth_reg);
        wdata      = push_value;
        raddr      = AW'(depth_reg - DW'(1));
        dreq.start = 1'b0;
        dreq.a     = a_reg;
        dreq.b     = b_reg;
        fin        = 1'b0;
        wr_done    = 1'b0;
        res_val    = pse_pkg::sat32(sum);
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    op_next   = func;
                    last_next = last;
                    fin       = last;
                    if (err_reg == pse_pkg::ST_OK && func <= pse_pkg::OP_DIV)
                    begin
                        if (func == pse_pkg::OP_PUSH)
                        begin
                            if (depth_reg < DW'(STACK_ENTRIES))
                            begin
                                we         = 1'b1;
                                depth_next = depth_reg + DW'(1);
                            end
                            else
                                err_next = pse_pkg::ST_OVERFLOW;
                        end
                        else if (depth_reg < DW'(2))
                            err_next = pse_pkg::ST_UNDERFLOW;
                        else
                        begin
                            fin        = 1'b0;
                            state_next = S_RDB;
                        end
                    end
                end
            end
            S_RDB:
            begin
                b_next     = $signed(rdata);
                raddr      = AW'(depth_reg - DW'(2));
                state_next = S_RDA;
            end
            S_RDA:
            begin
                a_next     = $signed(rdata);
                state_next = S_EXE;
            end
            S_EXE:
            begin
                case (op_reg)
                    pse_pkg::OP_MUL:
                    begin
                        prod_next  = 64'(a_reg) * 64'(b_reg);
                        state_next = S_MUL;
                    end
                    pse_pkg::OP_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            err_next   = pse_pkg::ST_DIVZERO;
                            state_next = S_IDLE;
                            fin        = last_reg;
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                        wr_done = 1'b1;
                endcase
            end
            S_MUL:
            begin
                if (mul_hi != '0 && mul_hi != '1)
                    res_val = prod_reg[63] ? 32'sh80000000 : 32'sh7fffffff;
                else
                    res_val = prod_reg[31+FRACTION_BITS -: 32];
                wr_done = 1'b1;
            end
            S_DIV:
            begin
                res_val = drsp.q;
                wr_done = drsp.done;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (wr_done)
        begin
            we         = 1'b1;
            waddr      = AW'(depth_reg - DW'(2));
            wdata      = res_val;
            depth_next = depth_reg - DW'(1);
            state_next = S_IDLE;
            fin        = last_reg;
        end
        if (we && waddr == '0)
            bottom_next = $signed(wdata);
        if (fin)
        begin
            out_valid_next = 1'b1;
            if (err_next != pse_pkg::ST_OK)
            begin
                st_next  = err_next;
                res_next = '0;
            end
            else if (depth_next != DW'(1))
            begin
                st_next  = pse_pkg::ST_DEPTH;
                res_next = '0;
            end
            else
            begin
                st_next  = pse_pkg::ST_OK;
                res_next = bottom_next;
            end
            depth_next = '0;
            err_next   = pse_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= pse_pkg::ST_OK;
            op_reg        <= pse_pkg::OP_PUSH;
            last_reg      <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            prod_reg      <= '0;
            res_reg       <= '0;
            st_reg        <= pse_pkg::ST_OK;
            bottom_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            prod_reg      <= prod_next;
            res_reg       <= res_next;
            st_reg        <= st_next;
            bottom_reg    <= bottom_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign status       = st_reg;

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `ASSERT_IMPL(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= DW'(STACK_ENTRIES))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_value))
endmodule
`default_nettype wire
